### rtl/core/ectc_pkg.sv
// shared types, constants and calendar tables for the epoch to calendar converter
`default_nettype none

package ectc_pkg;

  localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR   = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN    = 6'd60;
  localparam logic [2:0]  DAYS_PER_WEEK   = 3'd7;
  localparam logic [11:0] FIRST_YEAR      = 12'd1970;
  localparam logic [11:0] LAST_EXACT_YEAR = 12'd2099;
  localparam logic [11:0] CENTURY_2100    = 12'd2100;
  localparam logic [8:0]  DAYS_PER_YEAR   = 9'd365;

  // leap days through year 1969 net of the century terms
  localparam logic [12:0] LEAP_BIAS       = 13'd15;

  // reciprocals, exact over each operand range
  // days:    (secs >> 7) / 675, product >> 35
  // hours:   (tod >> 4) / 225, product >> 21
  // minutes: (rest >> 2) / 15, product >> 14
  // weeks:   sum / 7, product >> 16
  localparam logic [25:0] DAY_RECIP       = 26'd50903317;
  localparam logic [13:0] HOUR_RECIP      = 14'd9321;
  localparam logic [10:0] MIN_RECIP       = 11'd1093;
  localparam logic [13:0] WEEK_RECIP      = 14'd9363;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DAY,
    OP_TOD,
    OP_HOUR,
    OP_HOUR_REM,
    OP_MIN,
    OP_SEC,
    OP_YEAR,
    OP_MONTH,
    OP_WD_SUM,
    OP_WD_QUO,
    OP_WD_REM,
    OP_PUBLISH
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } status_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    case (month) inside
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // days before the first of the month in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] month);
    logic [8:0] cum;
    cum = 9'd0;
    case (month)
      4'd1:    cum = 9'd0;
      4'd2:    cum = 9'd31;
      4'd3:    cum = 9'd59;
      4'd4:    cum = 9'd90;
      4'd5:    cum = 9'd120;
      4'd6:    cum = 9'd151;
      4'd7:    cum = 9'd181;
      4'd8:    cum = 9'd212;
      4'd9:    cum = 9'd243;
      4'd10:   cum = 9'd273;
      4'd11:   cum = 9'd304;
      4'd12:   cum = 9'd334;
      default: cum = 9'd0;
    endcase
    return cum;
  endfunction

endpackage

`default_nettype wire

### rtl/core/epoch_seconds_to_calendar_top.sv
// top level of the epoch seconds to calendar date converter
`default_nettype none

// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into
// year, month, day of month, hour, minute, second and day of week (0 is
// Sunday), one result transaction per input transaction. Every fourth year
// counts as a leap year, which is exact through 2099; in_range_o drops for
// later years while the fields keep following that rule. In one conversion,
// six steps split the seconds into days, hour, minute and second by reciprocal
// multiplication, the year stepper takes one step per year since 1970 plus a
// final check, the month stepper one step per month passed plus a final check,
// sum, quotient and remainder steps form the weekday, and a last step moves the
// result into the output register once it is free or being taken. Work is on
// one item at a time; the input is ready again as soon as the result has moved
// into the output register, even if that result has not yet been taken. No
// clearing pass is needed after reset.
module epoch_seconds_to_calendar_top import ectc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input transaction
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] epoch_seconds_i,
  // result transaction
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [11:0]      year_o,
  output logic [3:0]       month_o,
  output logic [4:0]       day_of_month_o,
  output logic [4:0]       hour_o,
  output logic [5:0]       minute_o,
  output logic [5:0]       second_o,
  output logic [2:0]       weekday_o,
  output logic             in_range_o
);

  // command from controller to datapath, loop status back
  cmd_t    cmd;
  status_t status;

  // sequencer: splitting steps, year and month loops, result hand-off
  ectc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // working registers, reciprocal splitters and the output register set
  ectc_dp u_dp (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .epoch_seconds_i (epoch_seconds_i),
    .year_o          (year_o),
    .month_o         (month_o),
    .day_of_month_o  (day_of_month_o),
    .hour_o          (hour_o),
    .minute_o        (minute_o),
    .second_o        (second_o),
    .weekday_o       (weekday_o),
    .in_range_o      (in_range_o)
  );

endmodule

`default_nettype wire

### rtl/core/ectc_dp.sv
// datapath: reciprocal splitters, year and month steppers, output registers
`default_nettype none

module ectc_dp import ectc_pkg::*; (
  input  wire logic        clk_i,
  input  wire cmd_t        cmd_i,
  output status_t          status_o,
  input  wire logic [31:0] epoch_seconds_i,
  output logic [11:0]      year_o,
  output logic [3:0]       month_o,
  output logic [4:0]       day_of_month_o,
  output logic [4:0]       hour_o,
  output logic [5:0]       minute_o,
  output logic [5:0]       second_o,
  output logic [2:0]       weekday_o,
  output logic             in_range_o
);

  logic [31:0] secs_q, secs_d;
  logic [15:0] days_q, days_d;
  logic [16:0] tod_q, tod_d;
  logic [11:0] rest_q, rest_d;
  logic [11:0] year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;
  logic [5:0]  second_q, second_d;
  logic [12:0] wd_sum_q, wd_sum_d;
  logic [10:0] wd_quo_q, wd_quo_d;
  logic [2:0]  weekday_q, weekday_d;

  logic [50:0] day_prod;
  logic [31:0] day_secs;
  logic [31:0] tod_full;
  logic [26:0] hour_prod;
  logic [16:0] hour_secs;
  logic [16:0] rest_full;
  logic [20:0] min_prod;
  logic [11:0] min_secs;
  logic [11:0] sec_full;
  logic [26:0] wd_prod;
  logic [12:0] wd_mul7;
  logic [12:0] wd_rem_full;
  logic        leap;
  logic [8:0]  year_len;
  logic [4:0]  mlen;
  logic        month_go;
  logic [11:0] prev;
  logic [4:0]  mday;
  logic        corr;
  logic        late;
  logic [12:0] wd_sum;

  // quotients by reciprocal multiplication, remainders by multiply back
  assign day_prod    = {26'd0, secs_q[31:7]} * {25'd0, DAY_RECIP};
  assign day_secs    = {16'd0, days_q} * {15'd0, SECS_PER_DAY};
  assign tod_full    = secs_q - day_secs;
  assign hour_prod   = {14'd0, tod_q[16:4]} * {13'd0, HOUR_RECIP};
  assign hour_secs   = {12'd0, hour_q} * {5'd0, SECS_PER_HOUR};
  assign rest_full   = tod_q - hour_secs;
  assign min_prod    = {11'd0, rest_q[11:2]} * {10'd0, MIN_RECIP};
  assign min_secs    = {6'd0, minute_q} * {6'd0, SECS_PER_MIN};
  assign sec_full    = rest_q - min_secs;
  assign wd_prod     = {14'd0, wd_sum_q} * {13'd0, WEEK_RECIP};
  assign wd_mul7     = {2'd0, wd_quo_q} * {10'd0, DAYS_PER_WEEK};
  assign wd_rem_full = wd_sum_q - wd_mul7;

  assign leap     = (year_q[1:0] == 2'b00);
  assign year_len = DAYS_PER_YEAR + {8'd0, leap};
  assign mlen     = month_len(month_q, leap);
  assign month_go = (month_q < 4'd12) && (days_q >= {11'd0, mlen});

  assign status_o.year_done  = (days_q < {7'd0, year_len});
  assign status_o.month_done = !month_go;

  // weekday sum, reduced mod 7 later; 365 is 1 mod 7
  assign prev   = year_q - 12'd1;
  assign mday   = days_q[4:0] + 5'd1;
  assign corr   = leap && (month_q > 4'd2);
  assign late   = (prev >= CENTURY_2100);
  assign wd_sum = {1'b0, prev} + {3'd0, prev[11:2]} + {4'd0, cum_days(month_q)}
                + {8'd0, mday} + {12'd0, corr} - LEAP_BIAS - {12'd0, late};

  always_comb begin
    secs_d    = secs_q;
    days_d    = days_q;
    tod_d     = tod_q;
    rest_d    = rest_q;
    year_d    = year_q;
    month_d   = month_q;
    hour_d    = hour_q;
    minute_d  = minute_q;
    second_d  = second_q;
    wd_sum_d  = wd_sum_q;
    wd_quo_d  = wd_quo_q;
    weekday_d = weekday_q;
    case (cmd_i.op)
      OP_LOAD: begin
        secs_d  = epoch_seconds_i;
        year_d  = FIRST_YEAR;
        month_d = 4'd1;
      end
      OP_DAY:      days_d    = day_prod[50:35];
      OP_TOD:      tod_d     = tod_full[16:0];
      OP_HOUR:     hour_d    = hour_prod[25:21];
      OP_HOUR_REM: rest_d    = rest_full[11:0];
      OP_MIN:      minute_d  = min_prod[19:14];
      OP_SEC:      second_d  = sec_full[5:0];
      OP_YEAR: begin
        if (!status_o.year_done) begin
          days_d = days_q - {7'd0, year_len};
          year_d = year_q + 12'd1;
        end
      end
      OP_MONTH: begin
        if (month_go) begin
          days_d  = days_q - {11'd0, mlen};
          month_d = month_q + 4'd1;
        end
      end
      OP_WD_SUM:   wd_sum_d  = wd_sum;
      OP_WD_QUO:   wd_quo_d  = wd_prod[26:16];
      OP_WD_REM:   weekday_d = wd_rem_full[2:0];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    secs_q    <= secs_d;
    days_q    <= days_d;
    tod_q     <= tod_d;
    rest_q    <= rest_d;
    year_q    <= year_d;
    month_q   <= month_d;
    hour_q    <= hour_d;
    minute_q  <= minute_d;
    second_q  <= second_d;
    wd_sum_q  <= wd_sum_d;
    wd_quo_q  <= wd_quo_d;
    weekday_q <= weekday_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_PUBLISH) begin
      year_o         <= year_q;
      month_o        <= month_q;
      day_of_month_o <= mday;
      hour_o         <= hour_q;
      minute_o       <= minute_q;
      second_o       <= second_q;
      weekday_o      <= weekday_q;
      in_range_o     <= (year_q <= LAST_EXACT_YEAR);
    end
  end

endmodule

`default_nettype wire

### rtl/core/ectc_ctrl.sv
// controller: sequences the conversion steps and runs both handshakes
`default_nettype none

module ectc_ctrl import ectc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output cmd_t         cmd_o,
  input  wire status_t status_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DAY,
    S_TOD,
    S_HOUR,
    S_HOUR_REM,
    S_MIN,
    S_SEC,
    S_YEAR,
    S_MONTH,
    S_WD_SUM,
    S_WD_QUO,
    S_WD_REM,
    S_FINISH
  } state_e;

  state_e     state_q;
  logic       out_valid_q;
  logic       can_publish;

  assign can_publish = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.op = OP_NONE;
    case (state_q)
      S_IDLE:     cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      S_DAY:      cmd_o.op = OP_DAY;
      S_TOD:      cmd_o.op = OP_TOD;
      S_HOUR:     cmd_o.op = OP_HOUR;
      S_HOUR_REM: cmd_o.op = OP_HOUR_REM;
      S_MIN:      cmd_o.op = OP_MIN;
      S_SEC:      cmd_o.op = OP_SEC;
      S_YEAR:     cmd_o.op = OP_YEAR;
      S_MONTH:    cmd_o.op = OP_MONTH;
      S_WD_SUM:   cmd_o.op = OP_WD_SUM;
      S_WD_QUO:   cmd_o.op = OP_WD_QUO;
      S_WD_REM:   cmd_o.op = OP_WD_REM;
      S_FINISH:   cmd_o.op = can_publish ? OP_PUBLISH : OP_NONE;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_FINISH) && can_publish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_DAY;
          end
        end
        S_DAY:      state_q <= S_TOD;
        S_TOD:      state_q <= S_HOUR;
        S_HOUR:     state_q <= S_HOUR_REM;
        S_HOUR_REM: state_q <= S_MIN;
        S_MIN:      state_q <= S_SEC;
        S_SEC:      state_q <= S_YEAR;
        S_YEAR: begin
          if (status_i.year_done) begin
            state_q <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (status_i.month_done) begin
            state_q <= S_WD_SUM;
          end
        end
        S_WD_SUM:   state_q <= S_WD_QUO;
        S_WD_QUO:   state_q <= S_WD_REM;
        S_WD_REM:   state_q <= S_FINISH;
        S_FINISH: begin
          if (can_publish) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
